FILE: src/gbn_pkg.sv
package gbn_pkg;

    localparam int SEQ_COUNT_DEF   = 20;
    localparam int SEND_WINDOW_DEF = 10;

    localparam int TOTAL_W   = 16;
    localparam int TIMEOUT_W = 8;
    localparam int ACK_W     = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [OP_W-1:0] OP_SEND = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd20;

    typedef struct packed {
        logic capture;
        logic commit;
    } gbn_cmd_t;

    function automatic int win_max(input int sc, input int sw);
        return (sw < sc) ? sw : sc;
    endfunction

    function automatic int out_bits(input int sc, input int sw);
        int raw;
        raw = $clog2(sc + 1) + TOTAL_W + 2 + $clog2(sc) + $clog2(win_max(sc, sw) + 1);
        return ((raw + 7) / 8) * 8;
    endfunction

endpackage

FILE: src/gbn_ctrl.sv
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output gbn_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: src/gbn_datapath.sv
module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int SEQ_COUNT   = SEQ_COUNT_DEF,
    parameter int SEND_WINDOW = SEND_WINDOW_DEF,
    parameter int TDATA_W     = out_bits(SEQ_COUNT, SEND_WINDOW)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbn_cmd_t             cmd,
    input  logic [ACK_W-1:0]     s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 s_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int BASE_W = $clog2(SEQ_COUNT);
    localparam int SEQ_W  = $clog2(SEQ_COUNT + 1);
    localparam int WMAX   = win_max(SEQ_COUNT, SEND_WINDOW);
    localparam int OUT_W  = $clog2(WMAX + 1);
    localparam int CMP_W  = 10;
    localparam int RAW_W  = SEQ_W + TOTAL_W + 2 + BASE_W + OUT_W;

    localparam logic [OUT_W-1:0]  WMAX_V     = OUT_W'(WMAX);
    localparam logic [BASE_W-1:0] LAST_SLOT  = BASE_W'(SEQ_COUNT - 1);
    localparam logic [BASE_W-1:0] SEQ_V      = BASE_W'(SEQ_COUNT % (1 << BASE_W));
    localparam logic [CMP_W-1:0]  SEQ_CMP    = CMP_W'(SEQ_COUNT);

    logic [OP_W-1:0]      op_reg;
    logic [ACK_W-1:0]     ackn_reg;
    logic                 fin_reg;

    logic [TOTAL_W-1:0]   total_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [BASE_W-1:0]    base_reg,  base_next;
    logic [BASE_W-1:0]    nslot_reg, nslot_next;
    logic [OUT_W-1:0]     outst_reg, outst_next;
    logic [TOTAL_W-1:0]   sent_reg,  sent_next;
    logic [TIMEOUT_W-1:0] idle_reg,  idle_next;
    logic                 done_reg,  done_next;

    logic [SEQ_W-1:0]     seq_next;
    logic [TOTAL_W-1:0]   idx_next;
    logic                 grant;
    logic                 last_next;
    logic                 back_next;

    logic [RAW_W-1:0]     data_raw;
    logic [TDATA_W-1:0]   tdata_reg;
    logic                 tuser_reg;
    logic                 tlast_reg;

    logic [BASE_W-1:0]    ack_slot;
    logic [BASE_W-1:0]    ack_dist;
    logic                 ack_ok;
    logic [TIMEOUT_W:0]   tick_inc;

    always_comb
    begin
        ack_slot = BASE_W'(ackn_reg - ACK_W'(1));
        if (ack_slot >= base_reg)
        begin
            ack_dist = ack_slot - base_reg;
        end
        else
        begin
            ack_dist = ack_slot + SEQ_V - base_reg;
        end
        ack_ok = (ackn_reg != '0) && (CMP_W'(ackn_reg) <= SEQ_CMP)
                 && (CMP_W'(ack_dist) < CMP_W'(outst_reg));
        tick_inc = {1'b0, idle_reg} + 1'b1;
    end

    always_comb
    begin
        base_next  = base_reg;
        nslot_next = nslot_reg;
        outst_next = outst_reg;
        sent_next  = sent_reg;
        idle_next  = idle_reg;
        done_next  = done_reg;
        grant      = 1'b0;
        seq_next   = '0;
        idx_next   = '0;
        last_next  = 1'b0;
        back_next  = 1'b0;
        if (!done_reg)
        begin
            case (op_reg)
                OP_SEND:
                begin
                    if ((outst_reg < WMAX_V) && (sent_reg < total_reg))
                    begin
                        grant      = 1'b1;
                        seq_next   = SEQ_W'(nslot_reg) + SEQ_W'(1);
                        idx_next   = sent_reg;
                        last_next  = ({1'b0, sent_reg} + 1'b1) == {1'b0, total_reg};
                        nslot_next = (nslot_reg == LAST_SLOT) ? '0 : nslot_reg + 1'b1;
                        sent_next  = sent_reg + 1'b1;
                        outst_next = outst_reg + 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (fin_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (ack_ok)
                        begin
                            outst_next = outst_reg - OUT_W'(ack_dist) - 1'b1;
                            base_next  = (ack_slot == LAST_SLOT) ? '0 : ack_slot + 1'b1;
                        end
                        idle_next = '0;
                    end
                end
                OP_TICK:
                begin
                    if (tick_inc > {1'b0, timeout_reg})
                    begin
                        sent_next  = (sent_reg >= TOTAL_W'(outst_reg)) ?
                                     sent_reg - TOTAL_W'(outst_reg) : '0;
                        nslot_next = base_reg;
                        outst_next = '0;
                        idle_next  = '0;
                        back_next  = 1'b1;
                    end
                    else
                    begin
                        idle_next = tick_inc[TIMEOUT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // fields from bit 0 up: seq, index, went_back, done, base, outstanding
    assign data_raw = {outst_next, base_next, done_next, back_next, idx_next, seq_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            timeout_reg <= TIMEOUT_RST;
            base_reg    <= '0;
            nslot_reg   <= '0;
            outst_reg   <= '0;
            sent_reg    <= '0;
            idle_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL:   total_reg   <= cfg_data;
                    CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    default:     ;
                endcase
            end
            if (cmd.commit)
            begin
                base_reg  <= base_next;
                nslot_reg <= nslot_next;
                outst_reg <= outst_next;
                sent_reg  <= sent_next;
                idle_reg  <= idle_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_tuser;
            ackn_reg <= s_tdata;
            fin_reg  <= s_tlast;
        end
        if (cmd.commit)
        begin
            tdata_reg <= TDATA_W'(data_raw);
            tuser_reg <= grant;
            tlast_reg <= last_next;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;
    assign m_tlast = tlast_reg;

endmodule

FILE: src/go_back_n_sender_window_core.sv
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser operation, tdata ack_number, tlast ack_final
// m_*       out  m_tvalid/m_tready   tuser send_now, tdata status, tlast last_packet
// cfg_*     in   cfg_we              cfg_index, cfg_data
//
// one transfer in is first captured, then its window update is written into the output register
// a new transfer is taken while the previous result still waits on m_tready
// the update waits while the output register is full and not being taken
// rst_n clears the window, counters and done flag at once, no clearing pass
module go_back_n_sender_window_core
    import gbn_pkg::*;
#(
    parameter int SEQ_COUNT   = SEQ_COUNT_DEF,
    parameter int SEND_WINDOW = SEND_WINDOW_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ACK_W-1:0]     s_tdata,   // ack_number
    input  logic [OP_W-1:0]      s_tuser,   // operation
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // send_seq_number, packet_index, went_back, transfer_done, window_base, outstanding
    output logic [out_bits(SEQ_COUNT, SEND_WINDOW)-1:0] m_tdata,
    output logic                 m_tuser,   // send_now
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int TDATA_W  = out_bits(SEQ_COUNT, SEND_WINDOW);
    localparam int SEQ_W    = $clog2(SEQ_COUNT + 1);
    localparam int BASE_W   = $clog2(SEQ_COUNT);
    localparam int WMAX     = win_max(SEQ_COUNT, SEND_WINDOW);
    localparam int OUT_W    = $clog2(WMAX + 1);
    localparam int BACK_BIT = SEQ_W + TOTAL_W;
    localparam int DONE_BIT = BACK_BIT + 1;
    localparam int OUTST_LO = DONE_BIT + 1 + BASE_W;

    gbn_cmd_t cmd;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .SEQ_COUNT   (SEQ_COUNT),
        .SEND_WINDOW (SEND_WINDOW),
        .TDATA_W     (TDATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_grant_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[DONE_BIT])
        else $error("grant reported after transfer done");

    a_back_empties: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[BACK_BIT] |-> (m_tdata[OUTST_LO +: OUT_W] == '0) && !m_tuser)
        else $error("rewind left packets outstanding");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUTST_LO +: OUT_W] <= OUT_W'(WMAX))
        else $error("outstanding count exceeds send window");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && cmd.commit == $past(1'b0) ||
        !s_tready)
        else $error("second transfer taken during update");

endmodule
